@@ rtl/keyword_substitution_cipher_top_assert.svh @@
// Assertion macros for the keyword substitution cipher checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyword cipher: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define KSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyword cipher: next-cycle check failed");

`endif

@@ rtl/kscip_pkg.sv @@
// Shared types and constants for the keyword substitution cipher.
// No dependencies; used by the cell, the top level and the checker.
package kscip_pkg;

  // Position and letter index width; the alphabet never exceeds 32 letters.
  localparam int unsigned POS_W     = 5;
  localparam int unsigned ARR_DEPTH = 2 ** POS_W;

  localparam logic [7:0] LETTER_BASE = 8'd65;  // 'A'
  localparam logic [7:0] SPACE_CODE  = 8'd32;  // ' '

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_TEXT   = 2'd3
  } mode_e;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             clr;         // wipe the map
    logic             key_en;      // key letter request this cycle
    logic [POS_W-1:0] key_letter;  // letter index of the key request
    logic [POS_W-1:0] pos;         // next keyed position to assign
    logic             ptk_we;      // write keyed position pos
    logic [POS_W-1:0] ptk_letter;  // letter written at keyed position pos
  } cell_ctl_t;

endpackage

@@ rtl/kscip_cell.sv @@
// One cell of the cipher map: state of one letter and of one keyed position.
// Depends on kscip_pkg; the finish token moves one cell to the right per cycle.
module kscip_cell
  import kscip_pkg::*;
#(
  parameter int unsigned CELL_ID = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             token_i,
  output logic             token_o,
  output logic             claim_o,
  output logic             used_o,
  output logic [POS_W-1:0] ktp_o,
  output logic [POS_W-1:0] ptk_o
);

  localparam logic [POS_W-1:0] ID = POS_W'(CELL_ID);

  logic             used_q, used_d;
  logic [POS_W-1:0] ktp_q, ktp_d;
  logic [POS_W-1:0] ptk_q, ptk_d;
  logic             token_q;
  logic             key_hit;

  // Claim the next position when the finish token finds this letter unused
  assign claim_o = token_i & ~used_q;
  assign key_hit = ctl_i.key_en & (ctl_i.key_letter == ID) & ~used_q;

  always_comb begin
    used_d = used_q;
    ktp_d  = ktp_q;
    ptk_d  = ptk_q;
    if (ctl_i.clr) begin
      used_d = 1'b0;
      ktp_d  = '0;
      ptk_d  = '0;
    end else begin
      if (claim_o || key_hit) begin
        used_d = 1'b1;
        ktp_d  = ctl_i.pos;
      end
      if (ctl_i.ptk_we && (ctl_i.pos == ID)) begin
        ptk_d = ctl_i.ptk_letter;
      end
    end
  end

  // Hold letter state; pass the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      ktp_q   <= '0;
      ptk_q   <= '0;
      token_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      ktp_q   <= ktp_d;
      ptk_q   <= ptk_d;
      token_q <= token_i;
    end
  end

  assign token_o = token_q;
  assign used_o  = used_q;
  assign ktp_o   = ktp_q;
  assign ptk_o   = ptk_q;

endmodule

@@ rtl/keyword_substitution_cipher_top.sv @@
// Channel    | Direction | Handshake           | Payload
// input      | in        | in_valid_i/in_stall_o | mode_i, char_code_i
// result     | out       | out_valid_o/out_stall_i | out_char_o, bad_char_o
// config     | in        | cfg_valid_i/cfg_ready_o | cfg_direction_i
//
// Clear and key letter requests update the map on acceptance; a text result
// sits in the output register in the cycle after acceptance.
// Finish sends a token along the row of cells, one cell per cycle, and input
// is stalled until it leaves the row.
// Input also stalls while a held result is stalled downstream.
// Reset is asynchronous: empty map, direction set to encrypt.
//
// Top level of the keyword substitution cipher: control, lookup and
// output register around a row of kscip_cell; depends on kscip_pkg.
module keyword_substitution_cipher_top
  import kscip_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       bad_char_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_direction_i
);

  logic             dir_q;
  logic [POS_W-1:0] next_pos_q, next_pos_d;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             bad_char_q;

  logic                   in_acc;
  logic                   busy;
  mode_e                  mode;
  logic [7:0]             offset;
  logic                   is_letter;
  logic [POS_W-1:0]       idx;
  logic [POS_W-1:0]       lookup;
  logic                   key_place;
  logic                   any_claim;
  logic [POS_W-1:0]       claim_letter;
  cell_ctl_t              ctl;

  logic [ALPHABET_SIZE:0]   token;
  logic [ALPHABET_SIZE-1:0] claim;
  logic [ARR_DEPTH-1:0]     used_vec;
  logic [POS_W-1:0]         ktp_arr [ARR_DEPTH];
  logic [POS_W-1:0]         ptk_arr [ARR_DEPTH];

  // Accept when the row is idle and the output register can take a result
  assign busy        = |token[ALPHABET_SIZE:1];
  assign in_stall_o  = busy | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign mode        = mode_e'(mode_i);
  assign cfg_ready_o = 1'b1;

  // Decode the letter index of the incoming byte
  assign offset    = char_code_i - LETTER_BASE;
  assign is_letter = (char_code_i >= LETTER_BASE) && (offset < 8'(ALPHABET_SIZE));
  assign idx       = offset[POS_W-1:0];

  // Encode the letter that claims a position during finish
  always_comb begin
    claim_letter = '0;
    for (int k = 0; k < int'(ALPHABET_SIZE); k++) begin
      if (claim[k]) begin
        claim_letter = claim_letter | POS_W'(k);
      end
    end
  end
  assign any_claim = |claim;

  // Broadcast control to the row
  always_comb begin
    ctl            = '0;
    ctl.clr        = in_acc && (mode == MODE_CLEAR);
    ctl.key_en     = in_acc && (mode == MODE_KEY) && is_letter;
    ctl.key_letter = idx;
    ctl.pos        = next_pos_q;
    key_place      = ctl.key_en && !used_vec[idx];
    ctl.ptk_we     = key_place || any_claim;
    ctl.ptk_letter = any_claim ? claim_letter : idx;
  end

  assign token[0] = in_acc && (mode == MODE_FINISH);

  // Advance the position counter on every placement
  always_comb begin
    next_pos_d = next_pos_q;
    if (ctl.clr) begin
      next_pos_d = '0;
    end else if (ctl.ptk_we) begin
      next_pos_d = next_pos_q + 1'b1;
    end
  end

  // Row of letter cells
  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    kscip_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .token_i (token[k]),
      .token_o (token[k+1]),
      .claim_o (claim[k]),
      .used_o  (used_vec[k]),
      .ktp_o   (ktp_arr[k]),
      .ptk_o   (ptk_arr[k])
    );
  end

  // Tie off positions beyond the alphabet
  for (genvar k = ALPHABET_SIZE; k < ARR_DEPTH; k++) begin : g_pad
    assign used_vec[k] = 1'b0;
    assign ktp_arr[k]  = '0;
    assign ptk_arr[k]  = '0;
  end

  assign lookup = dir_q ? ptk_arr[idx] : ktp_arr[idx];

  // Hold direction, position counter and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b1;
      next_pos_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      bad_char_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dir_q <= cfg_direction_i;
      end
      next_pos_q <= next_pos_d;
      if (in_acc && (mode == MODE_TEXT)) begin
        out_valid_q <= 1'b1;
        if (is_letter) begin
          out_char_q <= LETTER_BASE + {{(8 - POS_W){1'b0}}, lookup};
          bad_char_q <= 1'b0;
        end else if (char_code_i == SPACE_CODE) begin
          out_char_q <= SPACE_CODE;
          bad_char_q <= 1'b0;
        end else begin
          out_char_q <= char_code_i;
          bad_char_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign bad_char_o  = bad_char_q;

endmodule

@@ rtl/kscip_checker.sv @@
// Port-level checks for the keyword substitution cipher, bound to the top.
// Depends on kscip_pkg and keyword_substitution_cipher_top_assert.svh.
`include "keyword_substitution_cipher_top_assert.svh"

module kscip_checker
  import kscip_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] mode_i,
  input logic [7:0] char_code_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       bad_char_o
);

  logic text_acc;
  logic finish_acc;

  assign text_acc   = in_valid_i && !in_stall_o && (mode_i == MODE_TEXT);
  assign finish_acc = in_valid_i && !in_stall_o && (mode_i == MODE_FINISH);

  // Hold a stalled result
  `KSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_char_o) && $stable(bad_char_o))

  // Pass a space unchanged and unflagged
  `KSC_ASSERT_NEXT(a_space_pass, text_acc && (char_code_i == SPACE_CODE), out_valid_o && (out_char_o == SPACE_CODE) && !bad_char_o)

  // Flag bytes below the alphabet that are not a space
  `KSC_ASSERT_NEXT(a_bad_flag, text_acc && (char_code_i < LETTER_BASE) && (char_code_i != SPACE_CODE), out_valid_o && bad_char_o && (out_char_o == $past(char_code_i)))

  // Stall input while the finish sweep runs
  `KSC_ASSERT_NEXT(a_finish_stall, finish_acc, in_stall_o)

endmodule

bind keyword_substitution_cipher_top kscip_checker u_kscip_checker (.*);
